/* hw/rtl/angle_frame_decoder_macros.svh */
// assertion macros for the angle frame decoder checker
// no dependencies; included by afd_checker.sv
`ifndef ANGLE_FRAME_DECODER_MACROS_SVH
`define ANGLE_FRAME_DECODER_MACROS_SVH

// checked only outside reset
`define AFD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define AFD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/afd_pkg.sv */
// shared constants and types of the angle frame decoder
// no dependencies; imported by every module of the block
package afd_pkg;

  localparam int NUM_ANGLES_DEF = 4;
  localparam int NUM_REPORT     = 4;
  localparam int Q_DEPTH        = 2;

  localparam int ANGLE_W    = 17;
  localparam int DIFF_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  START_BYTE_RST   = 8'd120;
  localparam logic [15:0] JUMP_LIMIT_RST   = 16'd3000;
  localparam logic [15:0] ANGLE_OFFSET_RST = 16'd3600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE   = 2'd0,
    REG_JUMP_LIMIT   = 2'd1,
    REG_ANGLE_OFFSET = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* hw/rtl/angle_frame_decoder.sv */
// Angle frame decoder, top level: configuration registers, front end, queue, back end.
// depends on afd_pkg, afd_front, afd_fifo, afd_back
//
// Usage: serial bytes enter on rx_byte with rx_valid/rx_stall, one per unstalled cycle.
// Outside a frame every byte but start_byte is dropped. After the start byte, one
// switch byte and NUM_ANGLES little-endian 16-bit words follow (1 + 2*NUM_ANGLES bytes).
// The last byte of a frame yields one result on res_valid/res_stall: held switch,
// angles a..d in signed tenths of a degree (word - angle_offset, kept only when the
// change is below jump_limit) and a mask of the angles that passed.
// A frame's record passes the frame queue, stage 1 and the result register in turn.
// Throughput: one byte every cycle while rx_stall is low; a frame is at least
// 2 + 2*NUM_ANGLES bytes. A two-entry frame queue parts the byte side from the
// result side; rx_stall rises only when it is full, which takes a result held back
// by res_stall while three more frames complete.
// A stalled result keeps its fields unchanged until taken.
// Reset (rst, synchronous): no frame open, held angles and switch zero, queue empty,
// registers back to start byte 120, jump limit 3000, offset 3600.
// Configuration: cfg_wen writes cfg_data to register cfg_index (0 start byte,
// 1 jump limit, 2 angle offset); other indexes are ignored.
module angle_frame_decoder import afd_pkg::*; #(
  parameter int NUM_ANGLES = NUM_ANGLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      rx_valid,
  output logic                      rx_stall,
  input  logic [7:0]                rx_byte,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic                      fine_switch,
  output logic signed [ANGLE_W-1:0] angle_a,
  output logic signed [ANGLE_W-1:0] angle_b,
  output logic signed [ANGLE_W-1:0] angle_c,
  output logic signed [ANGLE_W-1:0] angle_d,
  output logic [NUM_REPORT-1:0]     accepted_mask
);

  localparam int FRAME_W = 8 + 16 * NUM_ANGLES;

  logic [7:0]         start_byte;
  logic [15:0]        jump_limit;
  logic [15:0]        angle_offset;
  qstat_t             q_stat;
  logic               q_push;
  logic               q_pop;
  logic [FRAME_W-1:0] q_wdata;
  logic [FRAME_W-1:0] q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte   <= START_BYTE_RST;
      jump_limit   <= JUMP_LIMIT_RST;
      angle_offset <= ANGLE_OFFSET_RST;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_BYTE:   start_byte   <= cfg_data[7:0];
        REG_JUMP_LIMIT:   jump_limit   <= cfg_data[15:0];
        REG_ANGLE_OFFSET: angle_offset <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  afd_front #(
    .NUM_ANGLES (NUM_ANGLES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .start_byte (start_byte),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  afd_fifo #(
    .DATA_W (FRAME_W),
    .DEPTH  (Q_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .data_in  (q_wdata),
    .pop      (q_pop),
    .data_out (q_rdata),
    .stat     (q_stat)
  );

  afd_back #(
    .NUM_ANGLES (NUM_ANGLES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .jump_limit    (jump_limit),
    .angle_offset  (angle_offset),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .fine_switch   (fine_switch),
    .angle_a       (angle_a),
    .angle_b       (angle_b),
    .angle_c       (angle_c),
    .angle_d       (angle_d),
    .accepted_mask (accepted_mask)
  );

endmodule

/* hw/rtl/afd_fifo.sv */
// short frame queue between the byte front end and the decode back end
// depends on afd_pkg
module afd_fifo import afd_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] data_in,
  input  logic              pop,
  output logic [DATA_W-1:0] data_out,
  output qstat_t            stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign data_out   = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

/* hw/rtl/afd_front.sv */
// front end: start byte hunt and frame byte collection
// depends on afd_pkg; pushes one record per complete frame into afd_fifo
module afd_front import afd_pkg::*; #(
  parameter int NUM_ANGLES = NUM_ANGLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rx_valid,
  output logic                        rx_stall,
  input  logic [7:0]                  rx_byte,
  input  logic [7:0]                  start_byte,
  input  qstat_t                      q_stat,
  output logic                        q_push,
  output logic [8+16*NUM_ANGLES-1:0]  q_data
);

  localparam int STORE_BYTES = 2 * NUM_ANGLES;
  localparam int DATA_BYTES  = STORE_BYTES + 1;
  localparam int CNT_W       = $clog2(DATA_BYTES);
  localparam int IDX_W       = $clog2(STORE_BYTES);

  logic             in_frame;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       frame_bytes [STORE_BYTES];
  logic             accept;
  logic             last;

  assign rx_stall = q_stat.full;
  assign accept   = rx_valid && !q_stat.full;
  assign last     = (byte_count == CNT_W'(STORE_BYTES));
  assign q_push   = accept && in_frame && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (rx_byte == start_byte) begin
          in_frame   <= 1'b1;
          byte_count <= '0;
        end
      end else if (last) begin
        in_frame   <= 1'b0;
        byte_count <= '0;
      end else begin
        byte_count <= byte_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame && !last) begin
      frame_bytes[byte_count[IDX_W-1:0]] <= rx_byte;
    end
  end

  // record: switch byte, then one 16-bit word per angle
  assign q_data[7:0] = frame_bytes[0];

  for (genvar i = 0; i < NUM_ANGLES; i++) begin : g_word
    if (i == NUM_ANGLES - 1) begin : g_tail
      assign q_data[8+16*i +: 16] = {rx_byte, frame_bytes[2*i+1]};
    end else begin : g_body
      assign q_data[8+16*i +: 16] = {frame_bytes[2*i+2], frame_bytes[2*i+1]};
    end
  end

endmodule

/* hw/rtl/afd_back.sv */
// back end: angle conversion, jump filter, held state and result register
// depends on afd_pkg; pops frame records from afd_fifo
module afd_back import afd_pkg::*; #(
  parameter int NUM_ANGLES = NUM_ANGLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  qstat_t                      q_stat,
  input  logic [8+16*NUM_ANGLES-1:0]  q_data,
  output logic                        q_pop,
  input  logic [15:0]                 jump_limit,
  input  logic [15:0]                 angle_offset,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic                        fine_switch,
  output logic signed [ANGLE_W-1:0]   angle_a,
  output logic signed [ANGLE_W-1:0]   angle_b,
  output logic signed [ANGLE_W-1:0]   angle_c,
  output logic signed [ANGLE_W-1:0]   angle_d,
  output logic [NUM_REPORT-1:0]       accepted_mask
);

  logic                      s1_valid;
  logic [7:0]                s1_sw;
  logic signed [ANGLE_W-1:0] s1_angle  [NUM_ANGLES];
  logic signed [ANGLE_W-1:0] held      [NUM_ANGLES];
  logic signed [ANGLE_W-1:0] held_next [NUM_ANGLES];
  logic [NUM_ANGLES-1:0]     accept;
  logic                      held_switch;
  logic                      sw_next;
  logic signed [ANGLE_W-1:0] rep_angle [NUM_REPORT];
  logic [NUM_REPORT-1:0]     rep_mask;
  logic                      advance;

  assign advance = s1_valid && (!res_valid || !res_stall);
  assign q_pop   = !q_stat.empty && (!s1_valid || advance);

  // stage 1: raw word to tenths of a degree
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_sw <= q_data[7:0];
      for (int i = 0; i < NUM_ANGLES; i++) begin
        s1_angle[i] <= $signed({1'b0, q_data[8+16*i +: 16]}) - $signed({1'b0, angle_offset});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 2: jump filter per angle
  for (genvar i = 0; i < NUM_ANGLES; i++) begin : g_lane
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;

    assign diff = $signed({s1_angle[i][ANGLE_W-1], s1_angle[i]})
                - $signed({held[i][ANGLE_W-1], held[i]});
    assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign accept[i]    = (mag < {{(DIFF_W-16){1'b0}}, jump_limit});
    assign held_next[i] = accept[i] ? s1_angle[i] : held[i];
  end

  assign sw_next = (s1_sw <= 8'd1) ? s1_sw[0] : held_switch;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_switch <= 1'b0;
      for (int i = 0; i < NUM_ANGLES; i++) begin
        held[i] <= '0;
      end
    end else if (advance) begin
      held_switch <= sw_next;
      held        <= held_next;
    end
  end

  for (genvar j = 0; j < NUM_REPORT; j++) begin : g_rep
    if (j < NUM_ANGLES) begin : g_live
      assign rep_angle[j] = held_next[j];
      assign rep_mask[j]  = accept[j];
    end else begin : g_none
      assign rep_angle[j] = '0;
      assign rep_mask[j]  = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fine_switch   <= sw_next;
      angle_a       <= rep_angle[0];
      angle_b       <= rep_angle[1];
      angle_c       <= rep_angle[2];
      angle_d       <= rep_angle[3];
      accepted_mask <= rep_mask;
    end
  end

endmodule

/* hw/rtl/afd_checker.sv */
// port-level checks of the angle frame decoder, bound to the top level
// depends on afd_pkg and angle_frame_decoder_macros.svh
`include "angle_frame_decoder_macros.svh"

module afd_port_checker import afd_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      rx_valid,
  input logic                      rx_stall,
  input logic                      res_valid,
  input logic                      res_stall,
  input logic                      fine_switch,
  input logic signed [ANGLE_W-1:0] angle_a,
  input logic signed [ANGLE_W-1:0] angle_b,
  input logic signed [ANGLE_W-1:0] angle_c,
  input logic signed [ANGLE_W-1:0] angle_d,
  input logic [NUM_REPORT-1:0]     accepted_mask
);

  logic [3*ANGLE_W-1:0] angles_bcd;

  assign angles_bcd = {angle_b, angle_c, angle_d};

  `AFD_ASSERT_ALWAYS(a_rst_no_result, clk, rst |=> !res_valid, "result valid after reset")
  `AFD_ASSERT_ALWAYS(a_rst_no_stall, clk, rst |=> !rx_stall, "byte side stalled after reset")
  `AFD_ASSERT(a_stall_needs_backlog, clk, rst, (rx_valid && rx_stall) |-> res_valid, "byte stall without a pending result")
  `AFD_ASSERT(a_result_holds, clk, rst, (res_valid && res_stall) |=> (res_valid && $stable(fine_switch) && $stable(angle_a) && $stable(angles_bcd) && $stable(accepted_mask)), "stalled result changed")

endmodule

bind angle_frame_decoder afd_port_checker u_port_checker (.*);
